/* hw/rtl/lz4d_pkg.sv */
// Shared constants, codes and result type of the LZ4 block decoder.
// Used by the decode core and the top level; no dependencies.
package lz4d_pkg;

  localparam int unsigned HIST_AW    = 16;
  localparam int unsigned HIST_DEPTH = 1 << HIST_AW;
  localparam int unsigned CNT_W      = 24;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [3:0] NIBBLE_ESC = 4'd15;
  localparam logic [7:0] EXT_MORE   = 8'd255;
  localparam logic [4:0] MIN_MATCH  = 5'd4;

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_OK       = 3'd1,
    ST_TRUNC    = 3'd2,
    ST_OVER     = 3'd3,
    ST_BADOFF   = 3'd4,
    ST_MISMATCH = 3'd5
  } status_e;

  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    status_e    status;
    logic       block_end;
  } res_t;

endpackage

/* hw/rtl/lz4d_hist_ram.sv */
// History ring memory: one write port and one read port with registered data.
// Stand-alone generic RAM, no package dependency.
module lz4d_hist_ram #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/lz4d_core.sv */
// Decode core: parse state, counters, raw length register and history access.
// Depends on lz4d_pkg; drives the history RAM ports.
module lz4d_core
  import lz4d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CNT_W-1:0]   cfg_data_i,
  input  logic               proc_i,
  input  logic               opcode_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic [7:0]         ram_rdata_i,
  output logic               ram_we_o,
  output logic [HIST_AW-1:0] ram_waddr_o,
  output logic [7:0]         ram_wdata_o,
  output logic [HIST_AW-1:0] ram_raddr_o,
  output res_t               res_o
);

  typedef enum logic [2:0] {
    PH_TOKEN     = 3'd0,
    PH_LIT_EXT   = 3'd1,
    PH_LITERAL   = 3'd2,
    PH_OFF_LO    = 3'd3,
    PH_OFF_HI    = 3'd4,
    PH_MATCH_EXT = 3'd5,
    PH_COPY      = 3'd6
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [3:0]       tmn_q, tmn_d;
  logic [CNT_W-1:0] lit_q, lit_d;
  logic [CNT_W-1:0] ml_q, ml_d;
  logic [15:0]      off_q, off_d;
  logic [CNT_W-1:0] oc_q, oc_d;
  logic             drop_q, drop_d;
  logic             eac_q, eac_d;
  logic [CNT_W-1:0] raw_q;
  logic             byp_hit_q;
  logic [7:0]       byp_data_q;

  logic             fin, fail, restart;
  status_e          fail_code;
  logic [7:0]       copy_byte;
  logic [CNT_W:0]   ext_sum;
  logic [CNT_W-1:0] new_lit, new_ml;
  logic [15:0]      new_off;
  res_t             res;

  assign copy_byte = byp_hit_q ? byp_data_q : ram_rdata_i;

  always_comb begin
    phase_d     = phase_q;
    tmn_d       = tmn_q;
    lit_d       = lit_q;
    ml_d        = ml_q;
    off_d       = off_q;
    oc_d        = oc_q;
    drop_d      = drop_q;
    eac_d       = eac_q;
    fin         = 1'b0;
    fail        = 1'b0;
    restart     = 1'b0;
    fail_code   = ST_TRUNC;
    res         = '0;
    res.accepted = 1'b1;
    ram_we_o    = 1'b0;
    ram_waddr_o = oc_q[HIST_AW-1:0];
    ram_wdata_o = data_byte_i;
    ext_sum     = {1'b0, lit_q} + {{CNT_W-7{1'b0}}, data_byte_i};
    new_lit     = lit_q;
    new_ml      = ml_q;
    new_off     = off_q;

    if (proc_i) begin
      if (opcode_i) begin
        if (!drop_q && phase_q == PH_COPY) begin
          res.out_valid = 1'b1;
          res.out_byte  = copy_byte;
          ram_we_o      = 1'b1;
          ram_wdata_o   = copy_byte;
          oc_d          = oc_q + 1'b1;
          ml_d          = ml_q - 1'b1;
          if (ml_q == CNT_W'(1)) begin
            if (eac_q) begin
              fin = 1'b1;
            end else begin
              phase_d = PH_TOKEN;
            end
          end
        end
      end else if (drop_q) begin
        if (last_byte_i) begin
          drop_d  = 1'b0;
          restart = 1'b1;
        end
      end else begin
        case (phase_q)
          PH_TOKEN, PH_LIT_EXT: begin
            if (phase_q == PH_TOKEN) begin
              tmn_d   = data_byte_i[3:0];
              new_lit = {{CNT_W-4{1'b0}}, data_byte_i[7:4]};
            end else begin
              new_lit = ext_sum[CNT_W] ? CNT_MAX : ext_sum[CNT_W-1:0];
            end
            lit_d = new_lit;
            if ((phase_q == PH_TOKEN && data_byte_i[7:4] == NIBBLE_ESC) ||
                (phase_q == PH_LIT_EXT && data_byte_i == EXT_MORE)) begin
              if (last_byte_i) begin
                fail = 1'b1;
              end else begin
                phase_d = PH_LIT_EXT;
              end
            end else if (last_byte_i) begin
              if (new_lit != '0) begin
                fail = 1'b1;
              end else begin
                fin = 1'b1;
              end
            end else if (({1'b0, oc_q} + {1'b0, new_lit}) > {1'b0, raw_q}) begin
              fail      = 1'b1;
              fail_code = ST_OVER;
            end else begin
              phase_d = (new_lit != '0) ? PH_LITERAL : PH_OFF_LO;
            end
          end
          PH_LITERAL: begin
            if (last_byte_i && lit_q > CNT_W'(1)) begin
              fail = 1'b1;
            end else begin
              res.out_valid = 1'b1;
              res.out_byte  = data_byte_i;
              ram_we_o      = 1'b1;
              oc_d          = oc_q + 1'b1;
              lit_d         = lit_q - 1'b1;
              if (lit_q == CNT_W'(1)) begin
                if (last_byte_i) begin
                  fin = 1'b1;
                end else begin
                  phase_d = PH_OFF_LO;
                end
              end
            end
          end
          PH_OFF_LO: begin
            if (last_byte_i) begin
              fail = 1'b1;
            end else begin
              off_d   = {8'd0, data_byte_i};
              phase_d = PH_OFF_HI;
            end
          end
          PH_OFF_HI, PH_MATCH_EXT: begin
            ext_sum = {1'b0, ml_q} + {{CNT_W-7{1'b0}}, data_byte_i};
            if (phase_q == PH_OFF_HI) begin
              new_off = {data_byte_i, off_q[7:0]};
              new_ml  = CNT_W'(tmn_q) + CNT_W'(MIN_MATCH);
            end else begin
              new_ml  = ext_sum[CNT_W] ? CNT_MAX : ext_sum[CNT_W-1:0];
            end
            off_d = new_off;
            ml_d  = new_ml;
            if ((phase_q == PH_OFF_HI && tmn_q == NIBBLE_ESC) ||
                (phase_q == PH_MATCH_EXT && data_byte_i == EXT_MORE)) begin
              if (last_byte_i) begin
                fail = 1'b1;
              end else begin
                phase_d = PH_MATCH_EXT;
              end
            end else if (new_off == '0 || CNT_W'(new_off) > oc_q ||
                         32'(new_off) > HIST_DEPTH) begin
              fail      = 1'b1;
              fail_code = ST_BADOFF;
            end else if (({1'b0, oc_q} + {1'b0, new_ml}) > {1'b0, raw_q}) begin
              fail      = 1'b1;
              fail_code = ST_OVER;
            end else begin
              phase_d = PH_COPY;
              eac_d   = last_byte_i;
            end
          end
          PH_COPY: begin
            res.accepted = 1'b0;
          end
          default: begin
            restart = 1'b1;
          end
        endcase
      end

      if (fin) begin
        res.status    = (oc_d == raw_q) ? ST_OK : ST_MISMATCH;
        res.block_end = 1'b1;
        restart       = 1'b1;
      end
      if (fail) begin
        res.status    = fail_code;
        res.block_end = 1'b1;
        restart       = 1'b1;
        drop_d        = !last_byte_i;
      end
      if (restart) begin
        phase_d = PH_TOKEN;
        tmn_d   = '0;
        lit_d   = '0;
        ml_d    = '0;
        off_d   = '0;
        oc_d    = '0;
        eac_d   = 1'b0;
      end
    end

    res.copy_pending = !drop_d && phase_d == PH_COPY;
  end

  assign ram_raddr_o = oc_d[HIST_AW-1:0] - off_d[HIST_AW-1:0];
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOKEN;
      tmn_q   <= '0;
      lit_q   <= '0;
      ml_q    <= '0;
      off_q   <= '0;
      oc_q    <= '0;
      drop_q  <= 1'b0;
      eac_q   <= 1'b0;
      raw_q   <= '0;
      byp_hit_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tmn_q   <= tmn_d;
      lit_q   <= lit_d;
      ml_q    <= ml_d;
      off_q   <= off_d;
      oc_q    <= oc_d;
      drop_q  <= drop_d;
      eac_q   <= eac_d;
      byp_hit_q <= ram_we_o && (ram_waddr_o == ram_raddr_o);
      if (cfg_we_i) begin
        raw_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= ram_wdata_o;
  end

endmodule

/* hw/rtl/lz4_block_decompressor.sv */
// LZ4 block decoder top level: input register, decode core, history RAM, result register.
// Depends on lz4d_pkg, lz4d_core and lz4d_hist_ram.
//
// Send the compressed bytes of one LZ4 block with tuser low, tlast on the final
// byte; while copy_pending is high, send ticks (tuser high) to pull out match
// bytes, one per tick. Every request gives exactly one result, and one request
// is taken per clock cycle while the result output is not stalled; a result
// passes through the input register and the result register around the decode
// logic. The history RAM read is issued from the next decoder state, with a
// bypass for a byte written in the same cycle. The history RAM needs no
// clearing after reset. Write raw_length only while the block is idle.
module lz4_block_decompressor
  import lz4d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i,     // raw_length
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i, // data_byte
  input  logic             s_axis_tuser_i, // opcode
  input  logic             s_axis_tlast_i, // last_byte
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // accepted, out_valid, out_byte[7:0], copy_pending, status[2:0], zero fill
  output logic [15:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o  // block_end
);

  logic       s1_valid_q;
  logic       s1_op_q;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic       out_valid_q;
  res_t       out_res_q;
  logic       advance;
  res_t       res;

  logic               ram_we;
  logic [HIST_AW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic [HIST_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;

  assign advance         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  lz4d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .proc_i      (advance),
    .opcode_i    (s1_op_q),
    .data_byte_i (s1_data_q),
    .last_byte_i (s1_last_q),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .res_o       (res)
  );

  lz4d_hist_ram #(
    .AW (HIST_AW),
    .DW (8)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_op_q   <= s_axis_tuser_i;
      s1_data_q <= s_axis_tdata_i;
      s1_last_q <= s_axis_tlast_i;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_res_q.block_end;
  assign m_axis_tdata_o  = {2'b00, out_res_q.status, out_res_q.copy_pending,
                            out_res_q.out_byte, out_res_q.out_valid,
                            out_res_q.accepted};

endmodule

/* hw/rtl/lz4d_checker.sv */
// Port-level checks on the LZ4 block decoder results, bound to the top level.
// Depends on lz4d_pkg for the status codes and on the top-level ports.
module lz4d_checker
  import lz4d_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o || m_axis_tdata_o[13:11] == ST_RUN))
    else $error("status reported without block end");

  a_end_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      m_axis_tdata_o[13:11] >= ST_OK && m_axis_tdata_o[13:11] <= ST_MISMATCH)
    else $error("block end with invalid status");

  a_byte_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1] |-> m_axis_tdata_o[0])
    else $error("decoded byte on a refused request");

  a_end_no_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> !m_axis_tdata_o[10])
    else $error("copy pending after block end");

endmodule

bind lz4_block_decompressor lz4d_checker u_lz4d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
